FILE: rtl/pbe_pkg.sv
`default_nettype none
package pbe_pkg;
    localparam int MAX_POINTS_DEF = 256;
    localparam int MAX_DEGREE_DEF = 8;
    localparam int COORD_W        = 32;
    localparam int T_W            = 24;
    localparam int FRAC_W         = 16;
    localparam int DEG_W          = 4;
    localparam logic [DEG_W-1:0] DEGREE_RESET = 4'd3;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_EVAL   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [23:0]        t_param;
    } req_item_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] curve_x;
        logic signed [31:0] curve_y;
    } rsp_item_t;
endpackage
`default_nettype wire

FILE: rtl/pbe_if.sv
`default_nettype none
interface pbe_req_if;
    import pbe_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [23:0] t_param;
    modport source (output valid, req_type, coord_x, coord_y, t_param, input ready);
    modport sink   (input valid, req_type, coord_x, coord_y, t_param, output ready);
endinterface

interface pbe_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
    modport source (output valid, ok, curve_x, curve_y, input ready);
    modport sink   (input valid, ok, curve_x, curve_y, output ready);
endinterface

interface pbe_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/piecewise_bezier_evaluator.sv
`default_nettype none
// Clear, append and rejected requests: result valid the cycle after the input transfer.
// Evaluate: the segment's points are read (one read per cycle, registered), ST_CHECK settles, then
// degree*(degree+1)/2 interpolation steps on one shared multiplier per axis, each a
// multiply state (ST_MUL) then an add state (ST_ADD). One request in flight; a new
// request is taken only after the previous result has transferred.
// Reset clears point count, degree (to 3) and control state only.
module piecewise_bezier_evaluator #(
    parameter int MAX_POINTS = pbe_pkg::MAX_POINTS_DEF,
    parameter int MAX_DEGREE = pbe_pkg::MAX_DEGREE_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pbe_cfg_if.sink   cfg,
    pbe_req_if.sink   req,
    pbe_rsp_if.source rsp
);
    import pbe_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int WN = MAX_DEGREE + 1;
    localparam int WW = $clog2(WN + 1);
    localparam int SW = T_W - FRAC_W;
    localparam int PW = SW + DEG_W + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_CHECK = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [DEG_W-1:0] degree_reg;
    logic [CW-1:0]    count_reg;
    logic             busy_reg;
    logic             out_valid_reg;
    logic             out_ok_reg;
    logic signed [31:0] out_x_reg, out_y_reg;

    // point memories
    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];
    logic signed [31:0] rd_x_reg, rd_y_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    // evaluation registers
    logic signed [31:0] wx_reg [WN];
    logic signed [31:0] wy_reg [WN];
    logic [T_W-1:0] seg_pos_reg;   // base address of segment
    logic [FRAC_W:0] u_reg;        // 0..65536
    logic [WW-1:0]  rd_i_reg;      // read index issued
    logic           rd_pend_reg;
    logic [WW-1:0]  wr_i_reg;      // points captured
    logic [WW-1:0]  k_reg, i_reg;
    logic signed [50:0] px_reg, py_reg;

    assign cfg.ready = !busy_reg;
    assign req.ready = !busy_reg && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.ok = out_ok_reg;
    assign rsp.curve_x = out_x_reg;
    assign rsp.curve_y = out_y_reg;

    wire req_fire = req.valid && req.ready;
    wire rsp_fire = out_valid_reg && rsp.ready;

    // evaluation validity check: compare segment bounds seg*d and (seg+1)*d
    // against count-1 instead of dividing by the degree
    logic [SW-1:0] seg_in;
    logic [PW-1:0] seg_base;
    logic [PW-1:0] seg_after;
    logic [PW-1:0] seg_start;
    logic          eval_ok;
    logic          eval_end;
    always_comb
    begin
        seg_in = req.t_param[T_W-1:FRAC_W];
        seg_base = PW'(seg_in) * PW'(degree_reg);
        seg_after = seg_base + PW'(degree_reg);
        eval_ok = 1'b0;
        eval_end = 1'b0;
        if (degree_reg >= 1 && 32'(degree_reg) <= MAX_DEGREE
            && 32'(count_reg) > 32'(degree_reg))
        begin
            if (32'(seg_after) < 32'(count_reg))
                eval_ok = 1'b1;
            else if (32'(seg_base) < 32'(count_reg) && req.t_param[FRAC_W-1:0] == 0)
            begin
                eval_ok = 1'b1;
                eval_end = 1'b1;
            end
        end
        // end of curve runs the last segment at u=1
        seg_start = eval_end ? seg_base - PW'(degree_reg) : seg_base;
    end

    // read address, clamped to last entry
    logic [T_W+WW-1:0] addr_full;
    always_comb
    begin
        addr_full = (T_W+WW)'(seg_pos_reg) + (T_W+WW)'(rd_i_reg);
        if (addr_full >= (T_W+WW)'(MAX_POINTS))
            rd_addr = AW'(MAX_POINTS - 1);
        else
            rd_addr = addr_full[AW-1:0];
    end

    assign wr_en = req_fire && req.req_type == REQ_APPEND && 32'(count_reg) < MAX_POINTS;

    // memories
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[count_reg[AW-1:0]] <= req.coord_x;
            mem_y[count_reg[AW-1:0]] <= req.coord_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    // interpolation difference and floored product (arith shift floors)
    logic signed [32:0] dx, dy;
    assign dx = 33'(wx_reg[i_reg + 1'b1]) - 33'(wx_reg[i_reg]);
    assign dy = 33'(wy_reg[i_reg + 1'b1]) - 33'(wy_reg[i_reg]);

    // control sequencing; ST_CHECK is a settle state after the last capture
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_fire && req.req_type == REQ_EVAL && eval_ok)
                    state_next = ST_READ;
            ST_READ:  if (wr_i_reg == WW'(degree_reg) && rd_pend_reg) state_next = ST_CHECK;
            ST_CHECK: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:
                if (i_reg + 1'b1 == k_reg && k_reg == 1)
                    state_next = ST_IDLE;
                else
                    state_next = ST_MUL;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            degree_reg    <= DEGREE_RESET;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                degree_reg <= cfg.data;
            if (rsp_fire)
                out_valid_reg <= 1'b0;
            state_reg <= state_next;
            if (req_fire)
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                unique case (req.req_type)
                    REQ_CLEAR:
                    begin
                        count_reg <= '0;
                        out_ok_reg <= 1'b1;
                        out_valid_reg <= 1'b1;
                    end
                    REQ_APPEND:
                    begin
                        if (wr_en)
                            count_reg <= count_reg + 1'b1;
                        out_ok_reg <= wr_en;
                        out_valid_reg <= 1'b1;
                    end
                    REQ_EVAL:
                    begin
                        if (eval_ok)
                        begin
                            busy_reg <= 1'b1;
                            seg_pos_reg <= T_W'(seg_start);
                            u_reg <= eval_end ? (FRAC_W+1)'(1 << FRAC_W)
                                              : {1'b0, req.t_param[FRAC_W-1:0]};
                            rd_i_reg <= '0;
                            wr_i_reg <= '0;
                            rd_pend_reg <= 1'b0;
                        end
                        else
                        begin
                            out_ok_reg <= 1'b0;
                            out_valid_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        out_ok_reg <= 1'b0;
                        out_valid_reg <= 1'b1;
                    end
                endcase
            end
            unique case (state_reg)
                ST_READ:
                begin
                    // issue one read per cycle, capture the previous one
                    if (rd_pend_reg)
                    begin
                        wx_reg[wr_i_reg] <= rd_x_reg;
                        wy_reg[wr_i_reg] <= rd_y_reg;
                        wr_i_reg <= wr_i_reg + 1'b1;
                    end
                    rd_pend_reg <= rd_i_reg <= WW'(degree_reg);
                    if (rd_i_reg <= WW'(degree_reg))
                        rd_i_reg <= rd_i_reg + 1'b1;
                    k_reg <= WW'(degree_reg);
                    i_reg <= '0;
                end
                ST_MUL:
                begin
                    px_reg <= 51'(dx * $signed({1'b0, u_reg}));
                    py_reg <= 51'(dy * $signed({1'b0, u_reg}));
                end
                ST_ADD:
                begin
                    wx_reg[i_reg] <= wx_reg[i_reg] + 32'(px_reg >>> FRAC_W);
                    wy_reg[i_reg] <= wy_reg[i_reg] + 32'(py_reg >>> FRAC_W);
                    if (i_reg + 1'b1 == k_reg)
                    begin
                        i_reg <= '0;
                        k_reg <= k_reg - 1'b1;
                        if (k_reg == 1)
                        begin
                            busy_reg <= 1'b0;
                            out_ok_reg <= 1'b1;
                            out_valid_reg <= 1'b1;
                            out_x_reg <= wx_reg[0] + 32'(px_reg >>> FRAC_W);
                            out_y_reg <= wy_reg[0] + 32'(py_reg >>> FRAC_W);
                        end
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_POINTS) else $error("point count overflow");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.ready) else $error("request taken while busy");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.req_type == REQ_CLEAR) |=> count_reg == 0)
        else $error("clear did not empty store");
    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !busy_reg) else $error("busy while idle");
`endif
endmodule
`default_nettype wire
